>>> hdl/bsam_pkg.sv
// shared types and constants of the bank switch address mapper
// no dependencies
package bsam_pkg;

    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int PADDR_W     = 21;
    localparam int ROM_CNT_W   = 8;
    localparam int RAM_CNT_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = 8'd2;
    localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = 3'd0;
    localparam logic [ROM_CNT_W-1:0] ROM_CNT_SEC   = 8'd32;
    localparam logic [BYTE_W-1:0]    OPEN_BUS      = 8'hFF;
    localparam logic [3:0]           RAM_EN_KEY    = 4'hA;

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM_READ  = 3'd1,
        TGT_RAM_READ  = 3'd2,
        TGT_RAM_WRITE = 3'd3,
        TGT_REG       = 3'd4
    } target_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROM_BANK_COUNT = 2'd0,
        REG_RAM_BANK_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WR_RAM_ENABLE = 2'd0,
        WR_ROM_LOW    = 2'd1,
        WR_SECONDARY  = 2'd2,
        WR_MODE       = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] bus_address;
        logic [BYTE_W-1:0] write_byte;
    } bsam_item_t;

    typedef struct packed {
        logic [2:0]         target;
        logic [PADDR_W-1:0] physical_address;
        logic [BYTE_W-1:0]  byte_out;
    } bsam_result_t;

    typedef struct packed {
        logic                 ram_enabled;
        logic [4:0]           rom_bank_low;
        logic [1:0]           rom_bank_upper;
        logic [1:0]           ram_bank;
        logic                 banking_mode;
        logic [ROM_CNT_W-1:0] rom_bank_count;
        logic [RAM_CNT_W-1:0] ram_bank_count;
    } bsam_bank_t;

endpackage

>>> hdl/bsam_if.sv
// valid/ready channel interfaces: bus access, result and configuration write
// depends on bsam_pkg
interface bsam_item_if;
    import bsam_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0] write_byte;
    modport source (output valid, output action, output bus_address, output write_byte,
                    input ready);
    modport sink (input valid, input action, input bus_address, input write_byte,
                  output ready);
endinterface

interface bsam_result_if;
    import bsam_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         target;
    logic [PADDR_W-1:0] physical_address;
    logic [BYTE_W-1:0]  byte_out;
    modport source (output valid, output target, output physical_address, output byte_out,
                    input ready);
    modport sink (input valid, input target, input physical_address, input byte_out,
                  output ready);
endinterface

interface bsam_cfg_if;
    import bsam_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/bsam_bank_regs.sv
// size registers and bank switching registers with their write decode
// depends on bsam_pkg
module bsam_bank_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bsam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsam_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             upd,
    input  bsam_pkg::bsam_item_t             item,
    output bsam_pkg::bsam_bank_t             bank
);
    import bsam_pkg::*;

    bsam_bank_t bank_reg, bank_next;
    logic [ROM_CNT_W-1:0] mask;
    logic [4:0]           low_v;
    logic [1:0]           sec_v;
    logic                 sec_used;
    logic                 sec_ram;
    reg_sel_t             sel;

    assign mask     = bank_reg.rom_bank_count - 8'd1;
    assign low_v    = item.write_byte[4:0];
    assign sec_v    = item.write_byte[1:0];
    assign sec_used = (bank_reg.rom_bank_count > ROM_CNT_SEC) || (bank_reg.ram_bank_count > 3'd1);
    assign sec_ram  = (bank_reg.rom_bank_count <= ROM_CNT_SEC) && (bank_reg.ram_bank_count > 3'd1);
    assign sel      = reg_sel_t'(item.bus_address[14:13]);

    always_comb
    begin
        bank_next = bank_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROM_BANK_COUNT: bank_next.rom_bank_count = cfg_data;
                REG_RAM_BANK_COUNT: bank_next.ram_bank_count = cfg_data[RAM_CNT_W-1:0];
                default: ;
            endcase
        end
        if (upd)
        begin
            unique case (sel)
                WR_RAM_ENABLE: bank_next.ram_enabled = (item.write_byte[3:0] == RAM_EN_KEY);
                WR_ROM_LOW:
                begin
                    if (low_v == 5'd0)
                        bank_next.rom_bank_low = 5'd1;
                    else
                        bank_next.rom_bank_low = low_v & mask[4:0];
                end
                WR_SECONDARY:
                begin
                    priority if (sec_ram)
                        bank_next.ram_bank = sec_v;
                    else if (sec_used)
                        bank_next.rom_bank_upper = sec_v & mask[6:5];
                    else
                        bank_next.rom_bank_upper = bank_reg.rom_bank_upper;
                end
                WR_MODE: bank_next.banking_mode = item.write_byte[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.ram_enabled    <= 1'b0;
            bank_reg.rom_bank_low   <= 5'd1;
            bank_reg.rom_bank_upper <= 2'd0;
            bank_reg.ram_bank       <= 2'd0;
            bank_reg.banking_mode   <= 1'b0;
            bank_reg.rom_bank_count <= ROM_CNT_RESET;
            bank_reg.ram_bank_count <= RAM_CNT_RESET;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

>>> hdl/bsam_translate.sv
// address decode and rom/ram translation of one bus access
// depends on bsam_pkg
module bsam_translate (
    input  bsam_pkg::bsam_item_t   item,
    input  bsam_pkg::bsam_bank_t   bank,
    output bsam_pkg::bsam_result_t result
);
    import bsam_pkg::*;

    logic [ADDR_W-1:0]  addr;
    logic               ram_window;
    logic [14:0]        ram_off;
    logic [15:0]        ram_size;
    logic               ram_ok;
    logic [PADDR_W-1:0] rom_pa;
    logic [21:0]        rom_size;
    logic               rom_ok;

    assign addr       = item.bus_address;
    assign ram_window = (addr[15:13] == 3'b101);
    assign ram_off    = {(bank.banking_mode ? bank.ram_bank : 2'd0), addr[12:0]};
    assign ram_size   = {bank.ram_bank_count, 13'd0};
    assign ram_ok     = bank.ram_enabled && (bank.ram_bank_count != 3'd0) && ram_window
                        && ({1'b0, ram_off} < ram_size);
    assign rom_size   = {bank.rom_bank_count, 14'd0};
    assign rom_ok     = ({1'b0, rom_pa} < rom_size);

    always_comb
    begin
        if (addr[14])
            rom_pa = {bank.rom_bank_upper, bank.rom_bank_low, addr[13:0]};
        else
            rom_pa = {(bank.banking_mode ? bank.rom_bank_upper : 2'd0), 5'd0, addr[13:0]};
    end

    always_comb
    begin
        result.target           = TGT_NONE;
        result.physical_address = '0;
        result.byte_out         = '0;
        priority if (item.action && !addr[15])
        begin
            result.target = TGT_REG;
        end
        else if (item.action)
        begin
            if (ram_ok)
            begin
                result.target           = TGT_RAM_WRITE;
                result.physical_address = {6'd0, ram_off};
                result.byte_out         = item.write_byte;
            end
        end
        else if (!addr[15])
        begin
            if (rom_ok)
            begin
                result.target           = TGT_ROM_READ;
                result.physical_address = rom_pa;
            end
            else
                result.byte_out = OPEN_BUS;
        end
        else if (ram_ok)
        begin
            result.target           = TGT_RAM_READ;
            result.physical_address = {6'd0, ram_off};
        end
        else
        begin
            result.byte_out = OPEN_BUS;
        end
    end

endmodule

>>> hdl/bank_switch_address_mapper.sv
// top level of the bank switch address mapper: input register, translation, result register
// depends on bsam_pkg, bsam_if, bsam_bank_regs, bsam_translate
//
// channel   dir  beat contents
// request   in   action, bus_address, write_byte
// response  out  target, physical_address, byte_out
// cfg       in   index, data (register write, always ready)
//
// one beat per cycle while response is ready; path: input register, then result register
// register writes take effect for the very next beat
// a stalled response holds the result; request stays ready while the input stage can move
// reset restores the size registers and the bank registers to their reset values
module bank_switch_address_mapper (
    input  logic                 clk,
    input  logic                 rst_n,
    bsam_item_if.sink            request,
    bsam_result_if.source        response,
    bsam_cfg_if.sink             cfg
);
    import bsam_pkg::*;

    logic         s1_valid_reg, s1_valid_next;
    bsam_item_t   s1_item_reg;
    logic         out_valid_reg, out_valid_next;
    bsam_result_t out_reg;
    bsam_result_t result;
    bsam_bank_t   bank;
    bsam_item_t   in_item;
    logic         advance;
    logic         take;
    logic         upd;

    assign in_item = '{action: request.action, bus_address: request.bus_address,
                       write_byte: request.write_byte};
    assign advance = !out_valid_reg || response.ready;
    assign request.ready = advance || !s1_valid_reg;
    assign take    = request.valid && request.ready;
    assign upd     = s1_valid_reg && advance && s1_item_reg.action
                     && !s1_item_reg.bus_address[15];
    assign cfg.ready = 1'b1;

    bsam_bank_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .upd       (upd),
        .item      (s1_item_reg),
        .bank      (bank)
    );

    bsam_translate u_xlate (
        .item   (s1_item_reg),
        .bank   (bank),
        .result (result)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = take;
        end
        else if (take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= in_item;
        if (advance && s1_valid_reg)
            out_reg <= result;
    end

    assign response.valid            = out_valid_reg;
    assign response.target           = out_reg.target;
    assign response.physical_address = out_reg.physical_address;
    assign response.byte_out         = out_reg.byte_out;

    // a beat in the input stage reaches the result register when it moves
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("input stage beat lost");

    // the input stage never drops a beat while the result side is stalled
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input stage overwritten during stall");

    // open bus and ignored results never carry an address
    a_none_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.target == TGT_NONE)) |-> (out_reg.physical_address == '0))
        else $error("address on ignored result");

    // register updates report a zero address and a zero byte_out
    a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.target == TGT_REG))
        |-> ((out_reg.physical_address == '0) && (out_reg.byte_out == '0)))
        else $error("register update with nonzero fields");

endmodule

>>> tb/tb_bank_switch_address_mapper.sv
// self-checking testbench of bank_switch_address_mapper: a directed table, then random
// bus accesses over several bank-count settings, each result beat checked against a typed row or a predictor
// depends on bsam_pkg, bsam_if and the block itself
module tb_bank_switch_address_mapper;
    import bsam_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   PHASES          = 12;
    localparam int   ITEMS_PER_PHASE = 94;
    localparam logic [ROM_CNT_W-1:0] ROM_PLAN [8] = '{8'd2, 8'd128, 8'd32, 8'd64,
                                                      8'd0, 8'd255, 8'd1, 8'd16};
    localparam logic [RAM_CNT_W-1:0] RAM_PLAN [8] = '{3'd0, 3'd4, 3'd4, 3'd1,
                                                      3'd7, 3'd2, 3'd3, 3'd5};

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICTED,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        bsam_item_t            access;
        bsam_result_t          want;
    } stim_row_t;

    typedef struct packed {
        logic         typed;
        bsam_result_t want;
    } literal_t;

    logic clk = 1'b0;
    logic rst_n;

    bsam_item_if   req_ch ();
    bsam_result_if resp_ch ();
    bsam_cfg_if    cfg_ch ();

    bank_switch_address_mapper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (resp_ch),
        .cfg      (cfg_ch)
    );

    always #5 clk = ~clk;

    bsam_bank_t   mapper_regs;
    bsam_result_t translations_due [$];
    literal_t     typed_due [$];
    stim_row_t    directed [$];
    int unsigned  idle_pct  = 0;
    int unsigned  stall_pct = 0;
    int unsigned  error_count = 0;

    bsam_item_t   seen_access;
    bsam_result_t seen_result;
    bsam_result_t due_result;
    literal_t     seen_literal;

    function automatic bsam_result_t translate_access(bsam_item_t it);
        logic [21:0]          rom_limit;
        logic [15:0]          ram_limit;
        logic [ROM_CNT_W-1:0] bank_mask;
        logic                 sec_used;
        logic                 sec_ram;
        logic                 ram_hit;
        logic [15:0]          ram_offset;
        logic [20:0]          rom_byte_addr;
        bsam_result_t         r;
        rom_limit  = {mapper_regs.rom_bank_count, 14'd0};
        ram_limit  = {mapper_regs.ram_bank_count, 13'd0};
        bank_mask  = mapper_regs.rom_bank_count - 8'd1;
        sec_used   = mapper_regs.rom_bank_count > ROM_CNT_SEC || mapper_regs.ram_bank_count > 3'd1;
        sec_ram    = mapper_regs.rom_bank_count <= ROM_CNT_SEC && mapper_regs.ram_bank_count > 3'd1;
        ram_offset = it.bus_address - 16'hA000;
        if (mapper_regs.banking_mode)
            ram_offset = ram_offset | {1'b0, mapper_regs.ram_bank, 13'd0};
        ram_hit = mapper_regs.ram_enabled && mapper_regs.ram_bank_count != '0
                  && it.bus_address >= 16'hA000 && it.bus_address <= 16'hBFFF
                  && ram_offset < ram_limit;
        r = '0;
        if (it.action == ACT_WRITE)
        begin
            if (it.bus_address <= 16'h7FFF)
            begin
                r.target = TGT_REG;
                case (reg_sel_t'(it.bus_address[14:13]))
                    WR_RAM_ENABLE: mapper_regs.ram_enabled = it.write_byte[3:0] == RAM_EN_KEY;
                    WR_ROM_LOW:
                        mapper_regs.rom_bank_low = (it.write_byte[4:0] == 5'd0) ? 5'd1
                                                   : it.write_byte[4:0] & bank_mask[4:0];
                    WR_SECONDARY:
                        if (sec_ram)
                            mapper_regs.ram_bank = it.write_byte[1:0];
                        else if (sec_used)
                            mapper_regs.rom_bank_upper = it.write_byte[1:0] & bank_mask[6:5];
                    WR_MODE: mapper_regs.banking_mode = it.write_byte[0];
                    default: ;
                endcase
            end
            else if (ram_hit)
            begin
                r.target           = TGT_RAM_WRITE;
                r.physical_address = PADDR_W'(ram_offset);
                r.byte_out         = it.write_byte;
            end
        end
        else if (it.bus_address <= 16'h7FFF)
        begin
            if (it.bus_address[14])
                rom_byte_addr = {mapper_regs.rom_bank_upper, mapper_regs.rom_bank_low,
                                 it.bus_address[13:0]};
            else if (mapper_regs.banking_mode)
                rom_byte_addr = {mapper_regs.rom_bank_upper, 5'd0, it.bus_address[13:0]};
            else
                rom_byte_addr = {7'd0, it.bus_address[13:0]};
            if ({1'b0, rom_byte_addr} < rom_limit)
            begin
                r.target           = TGT_ROM_READ;
                r.physical_address = rom_byte_addr;
            end
            else
                r.byte_out = OPEN_BUS;
        end
        else if (ram_hit)
        begin
            r.target           = TGT_RAM_READ;
            r.physical_address = PADDR_W'(ram_offset);
        end
        else
            r.byte_out = OPEN_BUS;
        return r;
    endfunction

    function automatic bsam_item_t random_access();
        bsam_item_t  it;
        int unsigned pick;
        pick           = $urandom_range(99);
        it.action      = 1'($urandom_range(1));
        it.bus_address = 16'($urandom_range(16'hFFFF));
        it.write_byte  = 8'($urandom_range(255));
        if (pick < 30)
        begin
            it.action      = ACT_READ;
            it.bus_address = 16'($urandom_range(16'h7FFF));
        end
        else if (pick < 50)
            it.bus_address = 16'($urandom_range(16'hBFFF, 16'hA000));
        else if (pick < 80)
        begin
            it.action      = ACT_WRITE;
            it.bus_address = 16'($urandom_range(16'h7FFF));
            if (it.bus_address <= 16'h1FFF && $urandom_range(1) == 1)
                it.write_byte[3:0] = RAM_EN_KEY;
        end
        else if (pick < 90)
            it.bus_address = $urandom_range(1) == 1 ? 16'($urandom_range(16'h9FFF, 16'h8000))
                                                    : 16'($urandom_range(16'hFFFF, 16'hC000));
        return it;
    endfunction

    function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic stim_row_t access_row(logic act, logic [ADDR_W-1:0] addr,
                                             logic [BYTE_W-1:0] wbyte);
        stim_row_t row;
        row        = '0;
        row.kind   = ROW_PREDICTED;
        row.access = '{action: act, bus_address: addr, write_byte: wbyte};
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic act, logic [ADDR_W-1:0] addr,
                                            logic [BYTE_W-1:0] wbyte, target_t tgt,
                                            logic [PADDR_W-1:0] paddr,
                                            logic [BYTE_W-1:0] bout);
        stim_row_t row;
        row      = access_row(act, addr, wbyte);
        row.kind = ROW_TYPED;
        row.want = '{target: tgt, physical_address: paddr, byte_out: bout};
        return row;
    endfunction

    task automatic check_field(string name, logic [PADDR_W-1:0] want, logic [PADDR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 'h%0h got 'h%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic push_access(bsam_item_t it, logic typed, bsam_result_t want);
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        typed_due.push_back('{typed: typed, want: want});
        req_ch.valid       <= 1'b1;
        req_ch.action      <= it.action;
        req_ch.bus_address <= it.bus_address;
        req_ch.write_byte  <= it.write_byte;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (translations_due.size() != 0 || typed_due.size() != 0);
    endtask

    // predict on each accepted access beat, then check each accepted result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_ROM_BANK_COUNT)
                    mapper_regs.rom_bank_count = cfg_ch.data;
                else if (cfg_ch.index == REG_RAM_BANK_COUNT)
                    mapper_regs.ram_bank_count = cfg_ch.data[RAM_CNT_W-1:0];
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen_access  = '{action: req_ch.action, bus_address: req_ch.bus_address,
                                 write_byte: req_ch.write_byte};
                due_result   = translate_access(seen_access);
                seen_literal = typed_due.pop_front();
                translations_due.push_back(seen_literal.typed ? seen_literal.want : due_result);
            end
            if (resp_ch.valid && resp_ch.ready)
            begin
                seen_result = '{target: resp_ch.target, physical_address: resp_ch.physical_address,
                                byte_out: resp_ch.byte_out};
                if (translations_due.size() == 0)
                begin
                    $display("%0t: unexpected beat target %0d address 'h%0h byte 'h%0h", $time,
                             seen_result.target, seen_result.physical_address,
                             seen_result.byte_out);
                    error_count++;
                end
                else
                begin
                    due_result = translations_due.pop_front();
                    check_field("target", PADDR_W'(due_result.target),
                                PADDR_W'(seen_result.target));
                    check_field("physical_address", due_result.physical_address,
                                seen_result.physical_address);
                    check_field("byte_out", PADDR_W'(due_result.byte_out),
                                PADDR_W'(seen_result.byte_out));
                end
            end
        end
    end

    initial
    begin
        resp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            resp_ch.ready <= $urandom_range(99) >= stall_pct;
        end
    end

    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [ROM_CNT_W-1:0] rom_count;
        logic [RAM_CNT_W-1:0] ram_count;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_READ;
        req_ch.bus_address <= '0;
        req_ch.write_byte  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_ROM_BANK_COUNT;
        cfg_ch.data        <= '0;
        mapper_regs                = '0;
        mapper_regs.rom_bank_count = ROM_CNT_RESET;
        mapper_regs.ram_bank_count = RAM_CNT_RESET;
        mapper_regs.rom_bank_low   = 5'd1;

        // reset sizes: 2 rom banks, no ram
        directed.push_back(typed_row(ACT_READ, 16'h0000, 8'h00, TGT_ROM_READ, 21'h000000, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h4000, 8'hFF, TGT_ROM_READ, 21'h004000, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h7FFF, 8'h00, TGT_ROM_READ, 21'h007FFF, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h8000, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        directed.push_back(typed_row(ACT_READ, 16'hFFFF, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        directed.push_back(typed_row(ACT_WRITE, 16'hFFFF, 8'hFF, TGT_NONE, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'hA000, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        directed.push_back(typed_row(ACT_WRITE, 16'h0000, 8'h0A, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'hA000, 8'h5A, TGT_NONE, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h4000, 8'h03, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h2000, 8'h00, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h4000, 8'h00, TGT_ROM_READ, 21'h004000, 8'h00));
        // largest rom and ram, upper bits select rom
        directed.push_back(cfg_row(REG_ROM_BANK_COUNT, 8'd128));
        directed.push_back(cfg_row(REG_RAM_BANK_COUNT, 8'd4));
        directed.push_back(typed_row(ACT_WRITE, 16'h2000, 8'hFF, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h4000, 8'hFF, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h7FFF, 8'h00, TGT_ROM_READ, 21'h1FFFFF, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h6000, 8'h01, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h3FFF, 8'h00, TGT_ROM_READ, 21'h183FFF, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'hBFFF, 8'hA5, TGT_RAM_WRITE, 21'h001FFF, 8'hA5));
        directed.push_back(typed_row(ACT_READ, 16'hA000, 8'h00, TGT_RAM_READ, 21'h000000, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h1FFF, 8'h0B, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'hBFFF, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        // upper bits now select the ram bank
        directed.push_back(cfg_row(REG_ROM_BANK_COUNT, 8'd32));
        directed.push_back(typed_row(ACT_WRITE, 16'h0000, 8'h1A, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'h5FFF, 8'h02, TGT_REG, 21'h0, 8'h00));
        directed.push_back(typed_row(ACT_WRITE, 16'hB000, 8'h00, TGT_RAM_WRITE, 21'h005000, 8'h00));
        directed.push_back(typed_row(ACT_READ, 16'h0000, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        // ram bank beyond a single-bank ram
        directed.push_back(cfg_row(REG_RAM_BANK_COUNT, 8'd1));
        directed.push_back(typed_row(ACT_READ, 16'hA000, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        directed.push_back(typed_row(ACT_WRITE, 16'hA000, 8'h77, TGT_NONE, 21'h0, 8'h00));
        directed.push_back(cfg_row(REG_ROM_BANK_COUNT, 8'd0));
        directed.push_back(typed_row(ACT_READ, 16'h4000, 8'h00, TGT_NONE, 21'h0, OPEN_BUS));
        // sizes that are not powers of two
        directed.push_back(cfg_row(REG_ROM_BANK_COUNT, 8'd255));
        directed.push_back(cfg_row(REG_RAM_BANK_COUNT, 8'hFF));
        directed.push_back(access_row(ACT_WRITE, 16'h4000, 8'h02));
        directed.push_back(access_row(ACT_READ, 16'h6123, 8'h00));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                if (i == 0 || directed[i-1].kind != ROW_CFG)
                    quiesce();
                write_reg(directed[i].reg_index, directed[i].reg_value);
            end
            else
                push_access(directed[i].access, directed[i].kind == ROW_TYPED, directed[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiesce();
            if (phase < 8)
            begin
                rom_count = ROM_PLAN[phase];
                ram_count = RAM_PLAN[phase];
            end
            else
            begin
                rom_count = $urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                   : 8'(1 << $urandom_range(7, 1));
                ram_count = 3'($urandom_range(7));
            end
            write_reg(REG_ROM_BANK_COUNT, rom_count);
            write_reg(REG_RAM_BANK_COUNT, {5'($urandom_range(31)), ram_count});
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            repeat (ITEMS_PER_PHASE) push_access(random_access(), 1'b0, '0);
        end

        quiesce();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
